FILE: design/nearest_upsample_2d_top_defines.svh
// assertion macros for the upsampler rtl
// depends on nothing; included by files that carry concurrent checks
`ifndef NEAREST_UPSAMPLE_2D_TOP_DEFINES_SVH
`define NEAREST_UPSAMPLE_2D_TOP_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define NU2D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while in reset
`define NU2D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/nu2d_pkg.sv
// shared constants, types and helpers of the nearest-neighbour upsampler
// depends on nothing; imported by every module of the block
package nu2d_pkg;

    // tensor bounds
    localparam int MAX_WIDTH    = 512;
    localparam int MAX_HEIGHT   = 512;
    localparam int MAX_CHANNELS = 1024;
    localparam int MAX_SCALE    = 8;

    // counter widths
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CHAN_W = $clog2(MAX_CHANNELS);

    // register and field widths
    localparam int SCALE_W  = 4;
    localparam int HEIGHT_W = 10;
    localparam int WIDTH_W  = 10;
    localparam int PLANE_W  = 19;
    localparam int CFG_DATA_W = 19;
    localparam int CFG_ADDR_W = 2;
    localparam int IDX_W = 34;
    localparam int VAL_W = 32;
    localparam int SUB_W = 3;
    localparam int SS_W  = 2 * SCALE_W - 1;

    // intermediate product widths
    localparam int COLS_W  = COL_W + SCALE_W;
    localparam int ROWS_W  = ROW_W + SCALE_W;
    localparam int ROWSZ_W = WIDTH_W + SCALE_W;
    localparam int RO_W    = ROWS_W + ROWSZ_W;
    localparam int CP_W    = CHAN_W + PLANE_W;

    // work queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // register reset values
    localparam logic [SCALE_W-1:0]  SCALE_RST  = SCALE_W'(2);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(1);
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(1);
    localparam logic [PLANE_W-1:0]  PLANE_RST  = PLANE_W'(1);

    // register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SCALE  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_PLANE  = 2'd3
    } cfg_reg_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [SCALE_W-1:0]  scale;
        logic [SUB_W-1:0]    scale_m1;
        logic [SS_W-1:0]     scale_sq;
        logic [HEIGHT_W-1:0] in_height;
        logic [WIDTH_W-1:0]  in_width;
        logic [PLANE_W-1:0]  plane_size;
    } cfg_t;

    // one element's work for the back end
    typedef struct packed {
        logic [IDX_W-1:0]   row_start;
        logic [COLS_W-1:0]  col_start;
        logic [ROWSZ_W-1:0] row_size;
        logic [SUB_W-1:0]   scale_m1;
        logic [VAL_W-1:0]   value;
    } work_t;

    // scale register clamped to 1..MAX_SCALE
    function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] raw);
        logic [SCALE_W-1:0] s;
        s = raw;
        if (raw == '0)
        begin
            s = SCALE_W'(1);
        end
        else if (32'(raw) > MAX_SCALE)
        begin
            s = SCALE_W'(MAX_SCALE);
        end
        return s;
    endfunction

endpackage

FILE: design/nu2d_front.sv
// front end: takes requests, tracks position counters, computes base indices
// depends on nu2d_pkg
module nu2d_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [nu2d_pkg::VAL_W-1:0]    pixel_value,
    input  logic                          first_of_tensor,
    input  nu2d_pkg::cfg_t                cfg,
    input  logic                          q_full,
    output logic                          q_push,
    output nu2d_pkg::work_t               q_data
);
    import nu2d_pkg::*;

    logic advance;
    logic accept;

    logic [COL_W-1:0]  col_pos;
    logic [ROW_W-1:0]  row_pos;
    logic [CHAN_W-1:0] chan_pos;
    logic              col_wrap;
    logic              row_wrap;
    logic              chan_wrap;

    logic [COL_W-1:0]  col_count_reg,  col_count_next;
    logic [ROW_W-1:0]  row_count_reg,  row_count_next;
    logic [CHAN_W-1:0] chan_count_reg, chan_count_next;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;

    logic [VAL_W-1:0]  s1_value_reg;
    logic [CHAN_W-1:0] s1_chan_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;

    logic [VAL_W-1:0]   s2_value_reg;
    logic [CP_W-1:0]    s2_cp_reg;
    logic [ROWS_W-1:0]  s2_rs_reg;
    logic [COLS_W-1:0]  s2_cs_reg;
    logic [ROWSZ_W-1:0] s2_rowsz_reg;

    logic [VAL_W-1:0]   s3_value_reg;
    logic [IDX_W-1:0]   s3_cb_reg;
    logic [RO_W-1:0]    s3_ro_reg;
    logic [COLS_W-1:0]  s3_cs_reg;
    logic [ROWSZ_W-1:0] s3_rowsz_reg;

    // whole pipe moves unless the last stage is blocked by the queue
    assign advance = !(s3_valid_reg && q_full);
    assign full    = !advance;
    assign accept  = push && advance;

    // position of the incoming element
    always_comb
    begin
        col_pos  = first_of_tensor ? '0 : col_count_reg;
        row_pos  = first_of_tensor ? '0 : row_count_reg;
        chan_pos = first_of_tensor ? '0 : chan_count_reg;
        col_wrap  = (32'(col_pos) + 32'd1 >= 32'(cfg.in_width)) ||
                    (32'(col_pos) + 32'd1 >= 32'(MAX_WIDTH));
        row_wrap  = (32'(row_pos) + 32'd1 >= 32'(cfg.in_height)) ||
                    (32'(row_pos) + 32'd1 >= 32'(MAX_HEIGHT));
        chan_wrap = (32'(chan_pos) + 32'd1 >= 32'(MAX_CHANNELS));
    end

    // counter advance after each element
    always_comb
    begin
        col_count_next  = col_count_reg;
        row_count_next  = row_count_reg;
        chan_count_next = chan_count_reg;
        if (accept)
        begin
            col_count_next  = col_pos;
            row_count_next  = row_pos;
            chan_count_next = chan_pos;
            if (col_wrap)
            begin
                col_count_next = '0;
                if (row_wrap)
                begin
                    row_count_next  = '0;
                    chan_count_next = chan_wrap ? '0 : chan_pos + CHAN_W'(1);
                end
                else
                begin
                    row_count_next = row_pos + ROW_W'(1);
                end
            end
            else
            begin
                col_count_next = col_pos + COL_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg  <= '0;
            row_count_reg  <= '0;
            chan_count_reg <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
        end
        else
        begin
            col_count_reg  <= col_count_next;
            row_count_reg  <= row_count_next;
            chan_count_reg <= chan_count_next;
            if (advance)
            begin
                s1_valid_reg <= accept;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // datapath stages: capture, first products, second products
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_value_reg <= pixel_value;
            s1_chan_reg  <= chan_pos;
            s1_row_reg   <= row_pos;
            s1_col_reg   <= col_pos;

            s2_value_reg <= s1_value_reg;
            s2_cp_reg    <= CP_W'(s1_chan_reg) * CP_W'(cfg.plane_size);
            s2_rs_reg    <= ROWS_W'(s1_row_reg) * ROWS_W'(cfg.scale);
            s2_cs_reg    <= COLS_W'(s1_col_reg) * COLS_W'(cfg.scale);
            s2_rowsz_reg <= ROWSZ_W'(cfg.in_width) * ROWSZ_W'(cfg.scale);

            s3_value_reg <= s2_value_reg;
            s3_cb_reg    <= IDX_W'(s2_cp_reg) * IDX_W'(cfg.scale_sq);
            s3_ro_reg    <= RO_W'(s2_rs_reg) * RO_W'(s2_rowsz_reg);
            s3_cs_reg    <= s2_cs_reg;
            s3_rowsz_reg <= s2_rowsz_reg;
        end
    end

    // hand the finished work item to the queue
    assign q_push = s3_valid_reg && !q_full;
    always_comb
    begin
        q_data.row_start = s3_cb_reg + IDX_W'(s3_ro_reg);
        q_data.col_start = s3_cs_reg;
        q_data.row_size  = s3_rowsz_reg;
        q_data.scale_m1  = cfg.scale_m1;
        q_data.value     = s3_value_reg;
    end

endmodule

FILE: design/nu2d_queue.sv
// short work queue between front and back ends
// depends on nu2d_pkg
module nu2d_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  nu2d_pkg::work_t   wr_data,
    output logic              full,
    input  logic              rd_en,
    output nu2d_pkg::work_t   rd_data,
    output logic              not_empty
);
    import nu2d_pkg::*;

    work_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]    count_reg,  count_next;
    logic                do_wr;
    logic                do_rd;

    assign full      = (32'(count_reg) == Q_DEPTH);
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = entry_reg[rd_ptr_reg];

    // pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (Q_PTR_W+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (Q_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: design/nu2d_back.sv
// back end: expands each work item into scale squared write results
// depends on nu2d_pkg and nearest_upsample_2d_top_defines.svh
`include "nearest_upsample_2d_top_defines.svh"

module nu2d_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  nu2d_pkg::work_t               q_data,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [nu2d_pkg::IDX_W-1:0]    out_index,
    output logic [nu2d_pkg::VAL_W-1:0]    out_value,
    output logic                          run_last
);
    import nu2d_pkg::*;

    logic active_reg, active_next;
    logic out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]   rb_reg,        rb_next;
    logic [COLS_W-1:0]  col_reg,       col_next;
    logic [COLS_W-1:0]  col_start_reg, col_start_next;
    logic [ROWSZ_W-1:0] row_size_reg,  row_size_next;
    logic [VAL_W-1:0]   value_reg,     value_next;
    logic [SUB_W-1:0]   sm1_reg,       sm1_next;
    logic [SUB_W-1:0]   is_reg,        is_next;
    logic [SUB_W-1:0]   js_reg,        js_next;

    logic [IDX_W-1:0] out_index_reg;
    logic [VAL_W-1:0] out_value_reg;
    logic             out_last_reg;

    logic out_free;
    logic produce;
    logic last_copy;
    logic load;

    // result register frees when empty or taken this cycle
    assign out_free  = !out_valid_reg || pop;
    assign produce   = active_reg && out_free;
    assign last_copy = (is_reg == sm1_reg) && (js_reg == sm1_reg);
    assign load      = q_valid && (!active_reg || (produce && last_copy));
    assign q_pop     = load;

    assign empty     = !out_valid_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign run_last  = out_last_reg;

    // sub-row / sub-column walk
    always_comb
    begin
        active_next    = active_reg;
        rb_next        = rb_reg;
        col_next       = col_reg;
        col_start_next = col_start_reg;
        row_size_next  = row_size_reg;
        value_next     = value_reg;
        sm1_next       = sm1_reg;
        is_next        = is_reg;
        js_next        = js_reg;
        if (load)
        begin
            active_next    = 1'b1;
            rb_next        = q_data.row_start;
            col_next       = q_data.col_start;
            col_start_next = q_data.col_start;
            row_size_next  = q_data.row_size;
            value_next     = q_data.value;
            sm1_next       = q_data.scale_m1;
            is_next        = '0;
            js_next        = '0;
        end
        else if (produce)
        begin
            if (last_copy)
            begin
                active_next = 1'b0;
            end
            else if (js_reg == sm1_reg)
            begin
                js_next  = '0;
                col_next = col_start_reg;
                is_next  = is_reg + SUB_W'(1);
                rb_next  = rb_reg + IDX_W'(row_size_reg);
            end
            else
            begin
                js_next  = js_reg + SUB_W'(1);
                col_next = col_reg + COLS_W'(1);
            end
        end
    end

    // result register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            sm1_reg       <= '0;
            is_reg        <= '0;
            js_reg        <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            sm1_reg       <= sm1_next;
            is_reg        <= is_next;
            js_reg        <= js_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rb_reg        <= rb_next;
        col_reg       <= col_next;
        col_start_reg <= col_start_next;
        row_size_reg  <= row_size_next;
        value_reg     <= value_next;
        if (produce)
        begin
            out_index_reg <= rb_reg + IDX_W'(col_reg);
            out_value_reg <= value_reg;
            out_last_reg  <= last_copy;
        end
    end

    // checks on the copy walk
    `NU2D_ASSERT_NOW(a_row_in_range, clk, rst_n, active_reg, is_reg <= sm1_reg, "sub-row beyond scale")
    `NU2D_ASSERT_NOW(a_col_in_range, clk, rst_n, active_reg, js_reg <= sm1_reg, "sub-column beyond scale")
    `NU2D_ASSERT_NEXT(a_col_step, clk, rst_n, produce && !load && (js_reg != sm1_reg), col_reg == $past(col_reg) + COLS_W'(1), "column index did not step by one")
    `NU2D_ASSERT_NOW(a_pop_on_free, clk, rst_n, q_pop && active_reg, produce && last_copy, "work taken while a run is unfinished")

endmodule

FILE: design/nearest_upsample_2d_top.sv
// top level of the nearest-neighbour 2-d upsampler: registers and wiring
// depends on nu2d_pkg, nu2d_front, nu2d_queue and nu2d_back
//
//   channel   handshake          payload
//   input     push / full        pixel_value, first_of_tensor
//   result    pop / empty        out_index, out_value, run_last
//   config    cfg_wr_en          cfg_addr, cfg_wdata
//
// each element yields scale*scale results at one per cycle while the result
// register is free, walked by the back end's copy counters.
// an element passes the three front stages, the queue and the back end's work
// registers before its first result is registered on the result ports.
// reset restores the register defaults and zeroes the position counters.
// the three front stages and the four-entry queue keep taking elements while
// the back end or the result side stalls; full rises once the queue is full
// and the last front stage holds an element.
module nearest_upsample_2d_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [nu2d_pkg::VAL_W-1:0]        pixel_value,
    input  logic                              first_of_tensor,
    output logic                              empty,
    input  logic                              pop,
    output logic [nu2d_pkg::IDX_W-1:0]        out_index,
    output logic [nu2d_pkg::VAL_W-1:0]        out_value,
    output logic                              run_last,
    input  logic                              cfg_wr_en,
    input  logic [nu2d_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [nu2d_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import nu2d_pkg::*;

    logic [SCALE_W-1:0]  scale_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [PLANE_W-1:0]  plane_reg;

    logic [SCALE_W-1:0] scale_eff;
    cfg_t               cfg;

    logic  q_full;
    logic  q_push;
    work_t q_wr_data;
    logic  q_pop;
    work_t q_rd_data;
    logic  q_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RST;
            height_reg <= HEIGHT_RST;
            width_reg  <= WIDTH_RST;
            plane_reg  <= PLANE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_SCALE:  scale_reg  <= cfg_wdata[SCALE_W-1:0];
                REG_HEIGHT: height_reg <= cfg_wdata[HEIGHT_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_wdata[WIDTH_W-1:0];
                REG_PLANE:  plane_reg  <= cfg_wdata[PLANE_W-1:0];
                default:    ;
            endcase
        end
    end

    // clamped scale and its derived forms
    always_comb
    begin
        scale_eff      = eff_scale(scale_reg);
        cfg.scale      = scale_eff;
        cfg.scale_m1   = SUB_W'(scale_eff - SCALE_W'(1));
        cfg.scale_sq   = SS_W'(scale_eff) * SS_W'(scale_eff);
        cfg.in_height  = height_reg;
        cfg.in_width   = width_reg;
        cfg.plane_size = plane_reg;
    end

    // element intake and base index pipeline
    nu2d_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .pixel_value     (pixel_value),
        .first_of_tensor (first_of_tensor),
        .cfg             (cfg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_data          (q_wr_data)
    );

    // decoupling queue
    nu2d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_push),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_data   (q_rd_data),
        .not_empty (q_valid)
    );

    // copy expansion and result register
    nu2d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_rd_data),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .out_index (out_index),
        .out_value (out_value),
        .run_last  (run_last)
    );

endmodule
